// File: sv/rqbe_pkg.sv
// rqbe_pkg: sizes, action and status codes, and the command/status bundles
// shared by the ring queue controller and datapath. No dependencies.
`default_nettype none

package rqbe_pkg;

  localparam int DEPTH       = 16;
  localparam int RECORD_BITS = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int EXT_W       = CNT_W + 1;
  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_LIST  = 2'd1,
    ACT_ERASE = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  // what the output register loads on a result beat
  typedef enum logic [2:0] {
    EMIT_PLAIN,
    EMIT_REFUSED,
    EMIT_NOTHING,
    EMIT_ERASED_NOW,
    EMIT_ERASED,
    EMIT_RECORD
  } emit_t;

  typedef struct packed {
    logic  latch;
    logic  push_commit;
    logic  clear;
    logic  head_erase;
    logic  mid_setup;
    logic  list_setup;
    logic  list_step;
    logic  move_step;
    logic  emit;
    emit_t emit_kind;
  } dp_cmd_t;

  typedef struct packed {
    action_t action;
    logic    full;
    logic    list_zero;
    logic    list_last;
    logic    erase_none;
    logic    erase_at_head;
    logic    move_zero;
    logic    move_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/rqbe_dp.sv
// rqbe_dp: record store, ring pointers, capacity registers, erase/list
// arithmetic and the result register. Depends on rqbe_pkg.
`default_nettype none

module rqbe_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire rqbe_pkg::dp_cmd_t                cmd,
  output rqbe_pkg::dp_stat_t                    stat,
  input  wire logic                             cfg_we,
  input  wire logic [rqbe_pkg::CNT_W-1:0]       cfg_data,
  input  wire logic [rqbe_pkg::ACTION_W-1:0]    action,
  input  wire logic [rqbe_pkg::RECORD_BITS-1:0] record,
  input  wire logic [rqbe_pkg::IDX_W-1:0]       slot,
  input  wire logic [rqbe_pkg::CNT_W-1:0]       amount,
  output logic                                  done,
  output logic [rqbe_pkg::STATUS_W-1:0]         status,
  output logic [rqbe_pkg::IDX_W-1:0]            slot_out,
  output logic [rqbe_pkg::RECORD_BITS-1:0]      record_out,
  output logic [rqbe_pkg::CNT_W-1:0]            count,
  output logic                                  last
);

  logic [rqbe_pkg::RECORD_BITS-1:0] mem [rqbe_pkg::DEPTH];
  logic [rqbe_pkg::RECORD_BITS-1:0] rdata;
  logic [rqbe_pkg::RECORD_BITS-1:0] rec;
  rqbe_pkg::action_t                act;
  logic [rqbe_pkg::IDX_W-1:0]       slot_r;
  logic [rqbe_pkg::CNT_W-1:0]       amt;

  logic [rqbe_pkg::IDX_W-1:0] head, tail, ptr_a, ptr_b;
  logic [rqbe_pkg::CNT_W-1:0] occ, lim, cap_reg, num, remain;

  logic [rqbe_pkg::EXT_W-1:0] end_x, lim_x, slot_x, start_x, span;
  logic [rqbe_pkg::EXT_W-1:0] head_sum, src_sum, tail_sum;
  logic [rqbe_pkg::CNT_W-1:0] num_e, moves, list_n, cap_clamped;
  logic [rqbe_pkg::IDX_W-1:0] head_new, src_new, tail_new;
  logic [rqbe_pkg::IDX_W-1:0] waddr, raddr;
  logic [rqbe_pkg::RECORD_BITS-1:0] wdata;
  logic                       we;

  logic [rqbe_pkg::STATUS_W-1:0]    emit_status;
  logic [rqbe_pkg::IDX_W-1:0]       emit_slot;
  logic [rqbe_pkg::RECORD_BITS-1:0] emit_rec;
  logic [rqbe_pkg::CNT_W-1:0]       emit_count;
  logic                             emit_last;

  function automatic logic [rqbe_pkg::IDX_W-1:0] wrap_inc(
    input logic [rqbe_pkg::IDX_W-1:0] p,
    input logic [rqbe_pkg::CNT_W-1:0] l
  );
    logic [rqbe_pkg::CNT_W-1:0] s;
    s = rqbe_pkg::CNT_W'(p) + rqbe_pkg::CNT_W'(1);
    return (s == l) ? '0 : s[rqbe_pkg::IDX_W-1:0];
  endfunction

  // erase run arithmetic; for an erase not reported as empty, all values stay below twice the capacity
  always_comb begin
    end_x   = rqbe_pkg::EXT_W'(head) + rqbe_pkg::EXT_W'(occ);
    lim_x   = rqbe_pkg::EXT_W'(lim);
    slot_x  = rqbe_pkg::EXT_W'(slot_r);
    start_x = (slot_r < head) ? slot_x + lim_x : slot_x;
    span    = end_x - start_x;
    num_e   = (rqbe_pkg::EXT_W'(amt) < span) ? amt : span[rqbe_pkg::CNT_W-1:0];
    moves   = rqbe_pkg::CNT_W'(span - rqbe_pkg::EXT_W'(num_e));

    head_sum = rqbe_pkg::EXT_W'(head) + rqbe_pkg::EXT_W'(num_e);
    if (head_sum >= lim_x) head_sum = head_sum - lim_x;
    head_new = head_sum[rqbe_pkg::IDX_W-1:0];

    src_sum = slot_x + rqbe_pkg::EXT_W'(num_e);
    if (src_sum >= lim_x) src_sum = src_sum - lim_x;
    src_new = src_sum[rqbe_pkg::IDX_W-1:0];

    tail_sum = rqbe_pkg::EXT_W'(tail) + lim_x - rqbe_pkg::EXT_W'(num_e);
    if (tail_sum >= lim_x) tail_sum = tail_sum - lim_x;
    tail_new = tail_sum[rqbe_pkg::IDX_W-1:0];

    // occupancy never exceeds the depth, so no cap on the listed count
    list_n = (occ < amt) ? occ : amt;

    if (cap_reg == '0) begin
      cap_clamped = rqbe_pkg::CNT_W'(1);
    end else if (cap_reg > rqbe_pkg::CNT_W'(rqbe_pkg::DEPTH)) begin
      cap_clamped = rqbe_pkg::CNT_W'(rqbe_pkg::DEPTH);
    end else begin
      cap_clamped = cap_reg;
    end
  end

  always_comb begin
    stat.action        = act;
    stat.full          = (occ >= lim);
    stat.list_zero     = (list_n == '0);
    stat.list_last     = (remain == rqbe_pkg::CNT_W'(1));
    stat.erase_none    = (amt == '0) || (slot_x >= lim_x) || (end_x <= start_x);
    stat.erase_at_head = (slot_r == head);
    stat.move_zero     = (moves == '0);
    stat.move_last     = (remain == rqbe_pkg::CNT_W'(1));
  end

  // result fields for the beat being loaded
  always_comb begin
    emit_status = rqbe_pkg::ST_DONE;
    emit_slot   = '0;
    emit_rec    = '0;
    emit_count  = '0;
    emit_last   = 1'b1;
    case (cmd.emit_kind)
      rqbe_pkg::EMIT_REFUSED:    emit_status = rqbe_pkg::ST_FULL;
      rqbe_pkg::EMIT_NOTHING:    emit_status = rqbe_pkg::ST_NONE;
      rqbe_pkg::EMIT_ERASED_NOW: emit_count  = num_e;
      rqbe_pkg::EMIT_ERASED:     emit_count  = num;
      rqbe_pkg::EMIT_RECORD: begin
        emit_slot  = ptr_a;
        emit_rec   = rdata;
        emit_count = num;
        emit_last  = stat.list_last;
      end
      default: emit_status = rqbe_pkg::ST_DONE;
    endcase
  end

  assign we    = cmd.push_commit | cmd.move_step;
  assign waddr = cmd.move_step ? ptr_a : tail;
  assign wdata = cmd.move_step ? rdata : rec;
  assign raddr = (act == rqbe_pkg::ACT_ERASE) ? ptr_b : ptr_a;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      occ     <= '0;
      cap_reg <= rqbe_pkg::CNT_W'(rqbe_pkg::DEPTH);
      lim     <= rqbe_pkg::CNT_W'(rqbe_pkg::DEPTH);
      ptr_a   <= '0;
      ptr_b   <= '0;
      remain  <= '0;
      num     <= '0;
      done    <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cfg_we) begin
        cap_reg <= cfg_data;
      end
      if (cmd.push_commit) begin
        tail <= wrap_inc(tail, lim);
        occ  <= occ + rqbe_pkg::CNT_W'(1);
      end
      if (cmd.clear) begin
        lim  <= cap_clamped;
        head <= '0;
        tail <= '0;
        occ  <= '0;
      end
      if (cmd.head_erase) begin
        head <= head_new;
        occ  <= occ - num_e;
      end
      if (cmd.mid_setup) begin
        // later records slide down from src to dst
        tail   <= tail_new;
        occ    <= occ - num_e;
        ptr_a  <= slot_r;
        ptr_b  <= src_new;
        remain <= moves;
        num    <= num_e;
      end
      if (cmd.list_setup) begin
        ptr_a  <= head;
        remain <= list_n;
        num    <= list_n;
      end
      if (cmd.list_step) begin
        ptr_a  <= wrap_inc(ptr_a, lim);
        remain <= remain - rqbe_pkg::CNT_W'(1);
      end
      if (cmd.move_step) begin
        ptr_a  <= wrap_inc(ptr_a, lim);
        ptr_b  <= wrap_inc(ptr_b, lim);
        remain <= remain - rqbe_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act    <= rqbe_pkg::action_t'(action);
      rec    <= record;
      slot_r <= slot;
      amt    <= amount;
    end
    if (cmd.emit) begin
      status     <= emit_status;
      slot_out   <= emit_slot;
      record_out <= emit_rec;
      count      <= emit_count;
      last       <= emit_last;
    end
  end

endmodule

`default_nettype wire

// File: sv/rqbe_ctrl.sv
// rqbe_ctrl: sequencer for push, list, erase and clear; drives datapath
// commands from datapath status. Depends on rqbe_pkg.
`default_nettype none

module rqbe_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire rqbe_pkg::dp_stat_t stat,
  output rqbe_pkg::dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_LIST_RD,
    S_LIST_OUT,
    S_MOVE_RD,
    S_MOVE_WR
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd           = '0;
    cmd.emit_kind = rqbe_pkg::EMIT_PLAIN;
    state_next    = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        cmd.emit   = 1'b1;
        unique case (stat.action)
          rqbe_pkg::ACT_PUSH: begin
            if (stat.full) begin
              cmd.emit_kind = rqbe_pkg::EMIT_REFUSED;
            end else begin
              cmd.push_commit = 1'b1;
            end
          end
          rqbe_pkg::ACT_CLEAR: cmd.clear = 1'b1;
          rqbe_pkg::ACT_LIST: begin
            if (stat.list_zero) begin
              cmd.emit_kind = rqbe_pkg::EMIT_NOTHING;
            end else begin
              cmd.emit       = 1'b0;
              cmd.list_setup = 1'b1;
              state_next     = S_LIST_RD;
            end
          end
          rqbe_pkg::ACT_ERASE: begin
            if (stat.erase_none) begin
              cmd.emit_kind = rqbe_pkg::EMIT_NOTHING;
            end else if (stat.erase_at_head) begin
              cmd.head_erase = 1'b1;
              cmd.emit_kind  = rqbe_pkg::EMIT_ERASED_NOW;
            end else begin
              cmd.mid_setup = 1'b1;
              cmd.emit_kind = rqbe_pkg::EMIT_ERASED_NOW;
              // run ends at the tail: nothing to slide down
              if (!stat.move_zero) begin
                cmd.emit   = 1'b0;
                state_next = S_MOVE_RD;
              end
            end
          end
          default: cmd.emit = 1'b1;
        endcase
      end
      S_LIST_RD: state_next = S_LIST_OUT;
      S_LIST_OUT: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = rqbe_pkg::EMIT_RECORD;
        cmd.list_step = 1'b1;
        state_next    = stat.list_last ? S_IDLE : S_LIST_RD;
      end
      S_MOVE_RD: state_next = S_MOVE_WR;
      S_MOVE_WR: begin
        cmd.move_step = 1'b1;
        if (stat.move_last) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = rqbe_pkg::EMIT_ERASED;
          state_next    = S_IDLE;
        end else begin
          state_next = S_MOVE_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

`default_nettype wire

// File: sv/ring_queue_bulk_erase.sv
// ring_queue_bulk_erase: top level joining the sequencer and the datapath.
// Depends on rqbe_pkg, rqbe_ctrl and rqbe_dp.
//
// A command (action, record, slot, amount) is taken when start is high and
// busy is low; results come back one beat per cycle-long done strobe and
// cannot be held off, so a receiver must take every beat as it appears.
// Push, clear, refused or empty actions, erases at the head and erases that
// reach the last record hold busy for one cycle and put their single beat
// out in the cycle busy falls, so a new command can be taken once busy is
// low again. A list of n records alternates a read state and an output
// state for each record, one beat per record, and an erase in the middle of
// the run alternates a read and a write state for each of the m records
// behind the erased run: both walk the single record store one access at a
// time. The final beat always comes with busy falling. The capacity
// register is sampled only by clear. No clearing pass follows reset.
`default_nettype none

module ring_queue_bulk_erase (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [rqbe_pkg::ACTION_W-1:0]    action,
  input  wire logic [rqbe_pkg::RECORD_BITS-1:0] record,
  input  wire logic [rqbe_pkg::IDX_W-1:0]       slot,
  input  wire logic [rqbe_pkg::CNT_W-1:0]       amount,
  input  wire logic                             cfg_we,
  input  wire logic [rqbe_pkg::CNT_W-1:0]       cfg_data,
  output logic                                  done,
  output logic [rqbe_pkg::STATUS_W-1:0]         status,
  output logic [rqbe_pkg::IDX_W-1:0]            slot_out,
  output logic [rqbe_pkg::RECORD_BITS-1:0]      record_out,
  output logic [rqbe_pkg::CNT_W-1:0]            count,
  output logic                                  last
);

  rqbe_pkg::dp_cmd_t  cmd;
  rqbe_pkg::dp_stat_t stat;

  rqbe_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  rqbe_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .action     (action),
    .record     (record),
    .slot       (slot),
    .amount     (amount),
    .done       (done),
    .status     (status),
    .slot_out   (slot_out),
    .record_out (record_out),
    .count      (count),
    .last       (last)
  );

endmodule

`default_nettype wire

// File: sv/rqbe_checker.sv
// rqbe_checker: port-level checks on command acceptance and result beats,
// bound to ring_queue_bulk_erase. Depends on rqbe_pkg.
`default_nettype none

module rqbe_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         done,
  input wire logic [rqbe_pkg::STATUS_W-1:0] status,
  input wire logic [rqbe_pkg::CNT_W-1:0]    count,
  input wire logic                         last
);

  default clocking cb @(posedge clk);
  endclocking

  // an accepted command holds the block busy
  a_accept_busy: assert property (disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // a refused push is a single beat with no count
  a_refused_beat: assert property (disable iff (rst)
    done && status == rqbe_pkg::ST_FULL |-> last && count == '0)
    else $error("refused push beat malformed");

  // more beats of the same action follow while busy
  a_more_beats: assert property (disable iff (rst)
    done && !last |-> busy)
    else $error("non-final beat while idle");

  // the final beat is never directly followed by another
  a_last_gap: assert property (disable iff (rst)
    done && last |=> !done)
    else $error("beat straight after final beat");

  // going idle always comes with the final beat
  a_idle_last: assert property (disable iff (rst)
    $fell(busy) |-> done && last)
    else $error("busy fell without a final beat");

endmodule

bind ring_queue_bulk_erase rqbe_checker u_rqbe_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .status (status),
  .count  (count),
  .last   (last)
);

`default_nettype wire

// File: dv/tb_ring_queue_bulk_erase.sv
// tb_ring_queue_bulk_erase: self-checking testbench for the ring queue with bulk erase.
// Depends on rqbe_pkg and ring_queue_bulk_erase. A tracker class predicts every result
// beat from the accepted commands, and the beats coming back are checked in order.
module tb_ring_queue_bulk_erase;
  import rqbe_pkg::*;

  typedef struct {
    status_t                status;
    logic [IDX_W-1:0]       slot;
    logic [RECORD_BITS-1:0] rec;
    logic [CNT_W-1:0]       cnt;
    logic                   last;
  } beat_t;

  // mirrors queue state and holds the result beats still owed by the block
  class ring_queue_tracker;
    logic [RECORD_BITS-1:0] store [DEPTH];
    int unsigned head, tail, occupancy, active_cap, capacity_reg;
    int unsigned errors;
    beat_t       expected_beats [$];

    function new();
      head = 0;
      tail = 0;
      occupancy = 0;
      active_cap = DEPTH;
      capacity_reg = DEPTH;
      errors = 0;
    endfunction

    function void set_capacity(logic [CNT_W-1:0] v);
      capacity_reg = v;
    endfunction

    function void queue_beat(status_t st, int unsigned s, logic [RECORD_BITS-1:0] r,
                             int unsigned n, bit l);
      beat_t b;
      b.status = st;
      b.slot   = s[IDX_W-1:0];
      b.rec    = r;
      b.cnt    = n[CNT_W-1:0];
      b.last   = l;
      expected_beats.push_back(b);
    endfunction

    function void note_command(action_t act, logic [RECORD_BITS-1:0] rec,
                               logic [IDX_W-1:0] slt, logic [CNT_W-1:0] amt);
      int unsigned lim, n, s, first, stop, num;
      lim = active_cap;
      case (act)
        ACT_PUSH: begin
          if (occupancy >= lim) begin
            queue_beat(ST_FULL, 0, '0, 0, 1'b1);
          end else begin
            store[tail % lim] = rec;
            tail = (tail + 1) % lim;
            occupancy++;
            queue_beat(ST_DONE, 0, '0, 0, 1'b1);
          end
        end
        ACT_LIST: begin
          n = (occupancy < amt) ? occupancy : amt;
          if (n > DEPTH) n = DEPTH;
          if (n == 0) begin
            queue_beat(ST_NONE, 0, '0, 0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < n; i++) begin
              s = (head + i) % lim;
              queue_beat(ST_DONE, s, store[s], n, (i + 1 == n));
            end
          end
        end
        ACT_ERASE: begin
          // a full queue still ends at head plus occupancy, not at the tail
          stop  = head + occupancy;
          first = slt;
          num   = amt;
          if (num == 0 || first >= lim) begin
            queue_beat(ST_NONE, 0, '0, 0, 1'b1);
          end else begin
            if (first < head) first += lim;
            if (stop <= first) begin
              queue_beat(ST_NONE, 0, '0, 0, 1'b1);
            end else begin
              if (num > stop - first) num = stop - first;
              if (first == head) begin
                head = (head + num) % lim;
              end else begin
                // later records slide down over the erased run
                n = 0;
                for (int unsigned i = first + num; i < stop; i++) begin
                  store[(first + n) % lim] = store[(first + num + n) % lim];
                  n++;
                end
                tail = (tail + lim - num) % lim;
              end
              occupancy -= num;
              queue_beat(ST_DONE, 0, '0, num, 1'b1);
            end
          end
        end
        default: begin
          active_cap = (capacity_reg < 1) ? 1 : (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
          head = 0;
          tail = 0;
          occupancy = 0;
          queue_beat(ST_DONE, 0, '0, 0, 1'b1);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_beat(logic [STATUS_W-1:0] st, logic [IDX_W-1:0] so,
                             logic [RECORD_BITS-1:0] ro, logic [CNT_W-1:0] cn, logic la);
      beat_t want;
      if (expected_beats.size() == 0) begin
        $display("%0t: beat expected none got status %0h slot %0h record %0h count %0h last %0h",
                 $time, st, so, ro, cn, la);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      compare_field("status", want.status, st);
      compare_field("slot_out", want.slot, so);
      compare_field("record_out", want.rec, ro);
      compare_field("count", want.cnt, cn);
      compare_field("last", want.last, la);
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [ACTION_W-1:0]    action = ACT_PUSH;
  logic [RECORD_BITS-1:0] record = '0;
  logic [IDX_W-1:0]       slot = '0;
  logic [CNT_W-1:0]       amount = '0;
  logic                   cfg_we = 1'b0;
  logic [CNT_W-1:0]       cfg_data = '0;
  logic                   done;
  logic [STATUS_W-1:0]    status;
  logic [IDX_W-1:0]       slot_out;
  logic [RECORD_BITS-1:0] record_out;
  logic [CNT_W-1:0]       count;
  logic                   last;

  ring_queue_tracker tracker = new();

  ring_queue_bulk_erase i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .record     (record),
    .slot       (slot),
    .amount     (amount),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .done       (done),
    .status     (status),
    .slot_out   (slot_out),
    .record_out (record_out),
    .count      (count),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

  // everything is sampled on the edge that accepts it
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) tracker.set_capacity(cfg_data);
      if (start && !busy) tracker.note_command(action_t'(action), record, slot, amount);
      if (done) tracker.check_beat(status, slot_out, record_out, count, last);
    end
  end

  task automatic send(action_t act, logic [RECORD_BITS-1:0] rec, logic [IDX_W-1:0] slt,
                      logic [CNT_W-1:0] amt);
    start  <= 1'b1;
    action <= act;
    record <= rec;
    slot   <= slt;
    amount <= amt;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // block idle and every beat back, plus a margin before touching the register
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (tracker.expected_beats.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic run_random(int unsigned items, int unsigned gap_pct);
    int unsigned      pick, occ, cap;
    action_t          act;
    logic [IDX_W-1:0] slt;
    logic [CNT_W-1:0] amt;
    for (int unsigned k = 0; k < items; k++) begin
      pick = $urandom_range(0, 99);
      occ  = tracker.occupancy;
      cap  = tracker.active_cap;
      slt  = IDX_W'($urandom_range(0, DEPTH - 1));
      amt  = CNT_W'($urandom_range(0, DEPTH));
      if (pick < 50) begin
        act = ACT_PUSH;
      end else if (pick < 70) begin
        act = ACT_LIST;
      end else if (pick < 97) begin
        act = ACT_ERASE;
        // mostly aim inside the occupied run with short lengths
        if (occ > 0 && $urandom_range(0, 3) != 0)
          slt = IDX_W'((tracker.head + $urandom_range(0, occ - 1)) % cap);
        if ($urandom_range(0, 3) != 0) amt = CNT_W'($urandom_range(1, 3));
      end else begin
        act = ACT_CLEAR;
      end
      send(act, $urandom(), slt, amt);
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) pause($urandom_range(1, 11));
    end
  endtask

  initial begin
    logic [CNT_W-1:0] cap_value;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty cases, fill to the reset capacity, then erase of each kind
    send(ACT_LIST, $urandom(), 0, 0);
    send(ACT_ERASE, $urandom(), 0, 1);
    send(ACT_PUSH, 32'h0000_0000, 0, 0);
    send(ACT_PUSH, 32'hFFFF_FFFF, 0, 0);
    send(ACT_PUSH, 32'h5555_5555, 0, 0);
    send(ACT_PUSH, 32'hAAAA_AAAA, 0, 0);
    for (int i = 4; i < DEPTH; i++) begin
      send(ACT_PUSH, $urandom(), IDX_W'($urandom_range(0, DEPTH - 1)),
           CNT_W'($urandom_range(0, DEPTH)));
      if (i % 5 == 0) pause($urandom_range(1, 11));
    end
    send(ACT_PUSH, 32'hDEAD_0001, 0, 0);
    send(ACT_LIST, $urandom(), 0, DEPTH);
    send(ACT_ERASE, $urandom(), 5, 3);
    send(ACT_ERASE, $urandom(), 0, 2);
    send(ACT_ERASE, $urandom(), 9, DEPTH);
    send(ACT_LIST, $urandom(), 15, DEPTH);
    send(ACT_CLEAR, $urandom(), 0, 0);

    // register settings: zero and one past the top clamp, extremes, then random
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: cap_value = 0;
        1: cap_value = 1;
        2: cap_value = DEPTH + 1;
        3: cap_value = 2;
        4: cap_value = DEPTH;
        default: cap_value = CNT_W'($urandom_range(1, DEPTH));
      endcase
      settle();
      write_capacity(cap_value);
      send(ACT_CLEAR, $urandom(), IDX_W'($urandom_range(0, DEPTH - 1)),
           CNT_W'($urandom_range(0, DEPTH)));
      run_random(60, (p == 3 || p == 7) ? 0 : 30);
    end

    start <= 1'b0;
    do @(posedge clk); while (tracker.expected_beats.size() != 0);
    repeat (40) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_beats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
